FILE: rtl/hcbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, character codes and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 32;
  localparam int unsigned HEX_DIGIT_BITS  = 4;

  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  // size line flag bit positions
  localparam int unsigned FL_DIGIT  = 0;
  localparam int unsigned FL_CLOSED = 1;
  localparam int unsigned FL_EXT    = 2;

  typedef enum logic [2:0] {
    PH_LINE = 3'd0,
    PH_DATA = 3'd1,
    PH_CR   = 3'd2,
    PH_LF   = 3'd3,
    PH_DONE = 3'd4,
    PH_ERR  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] flags;
    logic       cr_pending;
  } ctl_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    status_t    status;
  } result_t;

  localparam ctl_t CTL_RESET = '{phase: PH_LINE, flags: 3'b000, cr_pending: 1'b0};

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF) ||
           (c == CH_VT) || (c == CH_FF);
  endfunction

  // {ok, value} for a hex digit in either case
  function automatic logic [HEX_DIGIT_BITS:0] hex_digit(input logic [7:0] c);
    logic [HEX_DIGIT_BITS:0] res;
    res = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      res = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      res = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return res;
  endfunction

endpackage

FILE: rtl/hcbd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_in_if
// Encoded byte channel: valid/ready handshake with byte and last marker.
// ----------------------------------------------------------------------------
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: rtl/hcbd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_out_if
// Result channel: valid/ready handshake with payload byte and body status.
// ----------------------------------------------------------------------------
interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic [1:0] status;

  modport source (output valid, output out_byte, output out_valid, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input status,
                  output ready);
endinterface

FILE: rtl/hcbd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_step
// Next-state and result logic for one encoded byte of a chunked body.
// ----------------------------------------------------------------------------
module hcbd_step #(
  parameter int unsigned LENGTH_BITS = hcbd_pkg::LENGTH_BITS_DEF
) (
  input  hcbd_pkg::ctl_t         ctl,
  input  logic [LENGTH_BITS-1:0] cnt,
  input  logic [7:0]             in_byte,
  input  logic                   in_last,
  output hcbd_pkg::ctl_t         ctl_nxt,
  output logic [LENGTH_BITS-1:0] cnt_nxt,
  output hcbd_pkg::result_t      res
);

  localparam int unsigned DB = hcbd_pkg::HEX_DIGIT_BITS;

  hcbd_pkg::phase_t       phase_upd;
  logic [2:0]             flags_upd;
  logic                   cr_upd;
  logic [LENGTH_BITS-1:0] cnt_upd;
  logic [DB:0]            hex;
  logic                   space;

  assign hex   = hcbd_pkg::hex_digit(in_byte);
  assign space = hcbd_pkg::is_space(in_byte);

  // next state
  always_comb begin
    phase_upd = ctl.phase;
    flags_upd = ctl.flags;
    cr_upd    = ctl.cr_pending;
    cnt_upd   = cnt;
    unique case (ctl.phase)
      hcbd_pkg::PH_LINE: begin
        cr_upd = 1'b0;
        if (ctl.cr_pending && in_byte == hcbd_pkg::CH_LF) begin
          if (!ctl.flags[hcbd_pkg::FL_DIGIT]) begin
            phase_upd = hcbd_pkg::PH_ERR;
          end else if (cnt == '0) begin
            phase_upd = hcbd_pkg::PH_DONE;
          end else begin
            phase_upd = hcbd_pkg::PH_DATA;
          end
        end else begin
          // a lone CR counts as whitespace
          if (ctl.cr_pending && !ctl.flags[hcbd_pkg::FL_EXT] &&
              ctl.flags[hcbd_pkg::FL_DIGIT]) begin
            flags_upd[hcbd_pkg::FL_CLOSED] = 1'b1;
          end
          if (in_byte == hcbd_pkg::CH_CR) begin
            cr_upd = 1'b1;
          end else if (!flags_upd[hcbd_pkg::FL_EXT]) begin
            if (in_byte == hcbd_pkg::CH_SEMI) begin
              flags_upd[hcbd_pkg::FL_EXT] = 1'b1;
            end else if (space) begin
              if (flags_upd[hcbd_pkg::FL_DIGIT]) begin
                flags_upd[hcbd_pkg::FL_CLOSED] = 1'b1;
              end
            end else if (!hex[DB] || flags_upd[hcbd_pkg::FL_CLOSED] ||
                         cnt[LENGTH_BITS-1 -: DB] != '0) begin
              phase_upd = hcbd_pkg::PH_ERR;
            end else begin
              cnt_upd = {cnt[LENGTH_BITS-DB-1:0], hex[DB-1:0]};
              flags_upd[hcbd_pkg::FL_DIGIT] = 1'b1;
            end
          end
        end
      end
      hcbd_pkg::PH_DATA: begin
        cnt_upd = cnt - LENGTH_BITS'(1);
        if (cnt == LENGTH_BITS'(1)) begin
          phase_upd = hcbd_pkg::PH_CR;
        end
      end
      hcbd_pkg::PH_CR: begin
        phase_upd = (in_byte == hcbd_pkg::CH_CR) ? hcbd_pkg::PH_LF : hcbd_pkg::PH_ERR;
      end
      hcbd_pkg::PH_LF: begin
        if (in_byte == hcbd_pkg::CH_LF) begin
          phase_upd = hcbd_pkg::PH_LINE;
          cnt_upd   = '0;
          flags_upd = '0;
          cr_upd    = 1'b0;
        end else begin
          phase_upd = hcbd_pkg::PH_ERR;
        end
      end
      hcbd_pkg::PH_DONE: begin
        phase_upd = hcbd_pkg::PH_DONE;
      end
      default: begin
        phase_upd = hcbd_pkg::PH_ERR;
      end
    endcase

    // re-arm after the last byte of a buffer
    if (in_last) begin
      ctl_nxt = hcbd_pkg::CTL_RESET;
      cnt_nxt = '0;
    end else begin
      ctl_nxt = '{phase: phase_upd, flags: flags_upd, cr_pending: cr_upd};
      cnt_nxt = cnt_upd;
    end
  end

  // result
  always_comb begin
    res.out_valid = (ctl.phase == hcbd_pkg::PH_DATA);
    res.out_byte  = res.out_valid ? in_byte : 8'h00;
    if (phase_upd == hcbd_pkg::PH_DONE) begin
      res.status = hcbd_pkg::ST_DONE;
    end else if (phase_upd == hcbd_pkg::PH_ERR || in_last) begin
      res.status = hcbd_pkg::ST_ERR;
    end else begin
      res.status = hcbd_pkg::ST_BUSY;
    end
  end

endmodule

FILE: rtl/http_chunked_body_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// Chunked transfer body decoder, one byte per cycle unless out_ch stalls.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries the encoded body one byte per transaction, with in_last on
//   the final byte of a buffer. out_ch returns exactly one result per input
//   byte: the payload byte with out_valid set when the byte is chunk data,
//   and a status of in progress, body complete or framing error.
//   Each result is registered and shown on out_ch the cycle after acceptance;
//   a byte is taken every cycle unless out_ch stalls, one parse update each.
//   The result register is refilled in the cycle it is taken, so a stall
//   on out_ch holds one result and stops input only while it is not taken.
//   After completion or an error every byte reports that status until the
//   byte marked last, after which the parser re-arms for a new body.
//   Reset returns the parser to the start of a size line and empties the
//   result register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core #(
  parameter int unsigned LENGTH_BITS = hcbd_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hcbd_in_if.sink     in_ch,
  hcbd_out_if.source  out_ch
);

  hcbd_pkg::ctl_t         ctl_r;
  hcbd_pkg::ctl_t         ctl_nxt;
  logic [LENGTH_BITS-1:0] cnt_r;
  logic [LENGTH_BITS-1:0] cnt_nxt;
  hcbd_pkg::result_t      res_r;
  hcbd_pkg::result_t      res_nxt;
  logic                   ovld_r;
  logic                   in_rdy;
  logic                   in_acc;

  assign in_rdy = !ovld_r || out_ch.ready;
  assign in_acc = in_ch.valid && in_rdy;

  hcbd_step #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .ctl     (ctl_r),
    .cnt     (cnt_r),
    .in_byte (in_ch.in_byte),
    .in_last (in_ch.in_last),
    .ctl_nxt (ctl_nxt),
    .cnt_nxt (cnt_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= hcbd_pkg::CTL_RESET;
      cnt_r  <= '0;
      ovld_r <= 1'b0;
    end else if (in_acc) begin
      ctl_r  <= ctl_nxt;
      cnt_r  <= cnt_nxt;
      ovld_r <= 1'b1;
    end else if (out_ch.ready) begin
      ovld_r <= 1'b0;
    end
  end

  // result payload: load on every accepted byte
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign in_ch.ready      = in_rdy;
  assign out_ch.valid     = ovld_r;
  assign out_ch.out_byte  = res_r.out_byte;
  assign out_ch.out_valid = res_r.out_valid;
  assign out_ch.status    = res_r.status;

endmodule
